/* hdl/chd_pkg.sv */
// Shared types and constants for the canonical Huffman decoder.
package chd_pkg;

    // Default configuration
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int NBITS_W = 4;
    localparam logic [NBITS_W-1:0] BYTE_BITS = NBITS_W'(BYTE_W);

    // Table load phase
    typedef enum logic [1:0] {
        PH_NONE,
        PH_COUNTS,
        PH_SYMBOLS,
        PH_READY
    } phase_t;

    // Bit engine sequencer
    typedef enum logic [1:0] {
        DS_IDLE,
        DS_BIT,
        DS_SYM,
        DS_FLUSH
    } dec_state_t;

    // Loader to bit engine control
    typedef struct packed {
        logic clear;   // new table started: drop code in progress
        logic cnt_we;  // write length count
        logic sym_we;  // write symbol
        logic ready;   // table loaded and sound
    } tbl_ctl_t;

endpackage

/* hdl/chd_loader.sv */
// Table loader: parses the serialized table and checks it as the counts arrive.
module chd_loader #(
    parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = chd_pkg::SYMBOL_COUNT_DEF,
    localparam int LL_W  = $clog2(MAX_CODE_LEN + 1),
    localparam int POS_W = $clog2(((SYMBOL_COUNT > MAX_CODE_LEN) ? SYMBOL_COUNT
                                                                 : MAX_CODE_LEN) + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        tbl_valid,
    input  logic                        tbl_start,
    input  logic [chd_pkg::BYTE_W-1:0]  tbl_byte,
    output chd_pkg::tbl_ctl_t           ctl,
    output logic [LL_W-1:0]             longest,
    output logic [POS_W-1:0]            wr_addr,
    output logic [chd_pkg::BYTE_W-1:0]  wr_data
);

    localparam int CNT_W = $clog2(SYMBOL_COUNT + 1);
    localparam int SUM_W = $clog2(SYMBOL_COUNT + 256);

    chd_pkg::phase_t    phase_reg, phase_next;
    logic [LL_W-1:0]    longest_reg, longest_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   expected_reg, expected_next;
    logic [7:0]         left_reg, left_next;
    logic               big_reg, big_next;
    logic               sound_reg, sound_next;

    logic [SUM_W-1:0]   sum;
    logic [8:0]         dbl;
    logic [POS_W:0]     pos_inc;

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= chd_pkg::PH_NONE;
            longest_reg  <= '0;
            pos_reg      <= '0;
            expected_reg <= '0;
            left_reg     <= 8'd1;
            big_reg      <= 1'b0;
            sound_reg    <= 1'b1;
        end else begin
            phase_reg    <= phase_next;
            longest_reg  <= longest_next;
            pos_reg      <= pos_next;
            expected_reg <= expected_next;
            left_reg     <= left_next;
            big_reg      <= big_next;
            sound_reg    <= sound_next;
        end
    end

    assign sum     = SUM_W'(expected_reg) + SUM_W'(tbl_byte);
    assign dbl     = {left_reg, 1'b0};
    assign pos_inc = (POS_W+1)'(pos_reg) + (POS_W+1)'(1);

    // Parse one table byte
    always_comb begin
        phase_next    = phase_reg;
        longest_next  = longest_reg;
        pos_next      = pos_reg;
        expected_next = expected_reg;
        left_next     = left_reg;
        big_next      = big_reg;
        sound_next    = sound_reg;
        ctl.clear     = 1'b0;
        ctl.cnt_we    = 1'b0;
        ctl.sym_we    = 1'b0;
        ctl.ready     = (phase_reg == chd_pkg::PH_READY);

        if (tbl_valid) begin
            if (tbl_start) begin
                ctl.clear     = 1'b1;
                pos_next      = '0;
                expected_next = '0;
                left_next     = 8'd1;
                big_next      = 1'b0;
                sound_next    = 1'b1;
                if (tbl_byte == '0 || 32'(tbl_byte) > 32'(MAX_CODE_LEN)) begin
                    longest_next = '0;
                    phase_next   = chd_pkg::PH_NONE;
                end else begin
                    longest_next = LL_W'(tbl_byte);
                    phase_next   = chd_pkg::PH_COUNTS;
                end
            end else begin
                case (phase_reg)
                    chd_pkg::PH_COUNTS: begin
                        ctl.cnt_we = 1'b1;
                        pos_next   = POS_W'(pos_inc);
                        // Kraft check, left saturates once it reaches 256
                        if (!big_reg) begin
                            if (dbl[8]) begin
                                big_next = 1'b1;
                            end else if (9'(tbl_byte) > dbl) begin
                                sound_next = 1'b0;
                            end else begin
                                left_next = 8'(dbl - 9'(tbl_byte));
                            end
                        end
                        if (sum > SUM_W'(SYMBOL_COUNT)) begin
                            expected_next = '0;
                            phase_next    = chd_pkg::PH_NONE;
                        end else begin
                            expected_next = CNT_W'(sum);
                            if (pos_inc >= (POS_W+1)'(longest_reg)) begin
                                pos_next   = '0;
                                phase_next = (sound_next && sum != '0) ?
                                             chd_pkg::PH_SYMBOLS : chd_pkg::PH_NONE;
                            end
                        end
                    end
                    chd_pkg::PH_SYMBOLS: begin
                        ctl.sym_we = 1'b1;
                        pos_next   = POS_W'(pos_inc);
                        if (pos_inc >= (POS_W+1)'(expected_reg)) begin
                            pos_next   = '0;
                            phase_next = chd_pkg::PH_READY;
                        end
                    end
                    default: begin
                        // stray table bytes are dropped
                    end
                endcase
            end
        end
    end

    assign longest   = longest_reg;
    assign wr_addr   = pos_reg;
    assign wr_data   = tbl_byte;

endmodule

/* hdl/chd_bit_engine.sv */
// Bit engine: count and symbol memories, one code bit per cycle while in DS_BIT, result staging.
module chd_bit_engine #(
    parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = chd_pkg::SYMBOL_COUNT_DEF,
    localparam int LL_W  = $clog2(MAX_CODE_LEN + 1),
    localparam int POS_W = $clog2(((SYMBOL_COUNT > MAX_CODE_LEN) ? SYMBOL_COUNT
                                                                 : MAX_CODE_LEN) + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  chd_pkg::tbl_ctl_t            ctl,
    input  logic [LL_W-1:0]              longest,
    input  logic [POS_W-1:0]             wr_addr,
    input  logic [chd_pkg::BYTE_W-1:0]   wr_data,
    input  logic                         dat_valid,
    input  logic                         dat_start,
    input  logic [chd_pkg::BYTE_W-1:0]   dat_byte,
    input  logic [chd_pkg::NBITS_W-1:0]  dat_nbits,
    output logic                         idle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [chd_pkg::BYTE_W-1:0]   out_symbol,
    output logic                         out_bad,
    output logic                         out_last
);

    localparam int CODE_W = MAX_CODE_LEN;
    localparam int LEN_W  = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam int SYM_W  = $clog2(SYMBOL_COUNT);
    localparam int CNT_W  = $clog2(SYMBOL_COUNT + 1);
    localparam int CMP_W  = (CODE_W > 8) ? CODE_W : 8;
    localparam int OFF_W  = ((CNT_W > 8) ? CNT_W : 8) + 1;

    // Memories
    logic [7:0]                  cnt_mem [MAX_CODE_LEN];
    logic [chd_pkg::BYTE_W-1:0]  sym_mem [SYMBOL_COUNT];
    logic [7:0]                  cnt_rdata_reg;
    logic [chd_pkg::BYTE_W-1:0]  sym_rdata_reg;
    logic                        sym_rd_en;
    logic [SYM_W-1:0]            sym_rd_addr;

    // Decoder state
    chd_pkg::dec_state_t          state_reg, state_next;
    logic [CODE_W-1:0]            partial_reg, partial_next;
    logic [CODE_W-1:0]            first_reg, first_next;
    logic [CNT_W-1:0]             base_reg, base_next;
    logic [LEN_W-1:0]             len_reg, len_next;

    // Work item and staging
    logic [chd_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic [chd_pkg::NBITS_W-1:0]  nbits_reg, nbits_next;
    logic                         pend_bad_reg, pend_bad_next;
    logic                         held_valid_reg, held_valid_next;
    logic [chd_pkg::BYTE_W-1:0]   held_sym_reg, held_sym_next;
    logic                         held_bad_reg, held_bad_next;
    logic                         out_valid_reg, out_valid_next;
    logic [chd_pkg::BYTE_W-1:0]   out_sym_reg, out_sym_next;
    logic                         out_bad_reg, out_bad_next;
    logic                         out_last_reg, out_last_next;

    // Datapath
    logic                         bit_in;
    logic [CODE_W-1:0]            code_shift;
    logic [CODE_W-1:0]            diff;
    logic                         hit;
    logic                         at_end;
    logic [OFF_W-1:0]             off;
    logic [CODE_W:0]              first_sum;
    logic [OFF_W-1:0]             base_sum;
    logic                         out_free;
    logic [chd_pkg::BYTE_W-1:0]   new_sym;

    // Count and symbol memories, registered reads
    always_ff @(posedge aclk) begin
        if (ctl.cnt_we) begin
            cnt_mem[wr_addr[LEN_W-1:0]] <= wr_data;
        end
        cnt_rdata_reg <= cnt_mem[len_next];
    end

    always_ff @(posedge aclk) begin
        if (ctl.sym_we) begin
            sym_mem[wr_addr[SYM_W-1:0]] <= wr_data;
        end
        if (sym_rd_en) begin
            sym_rdata_reg <= sym_mem[sym_rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= chd_pkg::DS_IDLE;
            partial_reg    <= '0;
            first_reg      <= '0;
            base_reg       <= '0;
            len_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            partial_reg    <= partial_next;
            first_reg      <= first_next;
            base_reg       <= base_next;
            len_reg        <= len_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        nbits_reg    <= nbits_next;
        pend_bad_reg <= pend_bad_next;
        held_sym_reg <= held_sym_next;
        held_bad_reg <= held_bad_next;
        out_sym_reg  <= out_sym_next;
        out_bad_reg  <= out_bad_next;
        out_last_reg <= out_last_next;
    end

    // One step of the first-code / index decode
    assign bit_in     = byte_reg[chd_pkg::BYTE_W-1];
    assign code_shift = CODE_W'({partial_reg, bit_in});
    assign diff       = code_shift - first_reg;
    assign hit        = (code_shift >= first_reg) &&
                        (CMP_W'(diff) < CMP_W'(cnt_rdata_reg));
    assign at_end     = ((LL_W+1)'(len_reg) + (LL_W+1)'(1)) >= (LL_W+1)'(longest);
    assign off        = OFF_W'(base_reg) + OFF_W'(diff);
    assign first_sum  = (CODE_W+1)'(first_reg) + (CODE_W+1)'(cnt_rdata_reg);
    assign base_sum   = OFF_W'(base_reg) + OFF_W'(cnt_rdata_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign new_sym    = pend_bad_reg ? '0 : sym_rdata_reg;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        partial_next    = partial_reg;
        first_next      = first_reg;
        base_next       = base_reg;
        len_next        = len_reg;
        byte_next       = byte_reg;
        nbits_next      = nbits_reg;
        pend_bad_next   = pend_bad_reg;
        held_valid_next = held_valid_reg;
        held_sym_next   = held_sym_reg;
        held_bad_next   = held_bad_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sym_next    = out_sym_reg;
        out_bad_next    = out_bad_reg;
        out_last_next   = out_last_reg;
        sym_rd_en       = 1'b0;
        sym_rd_addr     = off[SYM_W-1:0];

        case (state_reg)
            chd_pkg::DS_IDLE: begin
                if (ctl.clear || (dat_valid && dat_start)) begin
                    partial_next = '0;
                    first_next   = '0;
                    base_next    = '0;
                    len_next     = '0;
                end
                if (dat_valid) begin
                    if (!ctl.ready) begin
                        // no table: one bad result
                        held_valid_next = 1'b1;
                        held_sym_next   = '0;
                        held_bad_next   = 1'b1;
                        state_next      = chd_pkg::DS_FLUSH;
                    end else if (dat_nbits != '0) begin
                        byte_next  = dat_byte;
                        nbits_next = (dat_nbits > chd_pkg::BYTE_BITS) ?
                                     chd_pkg::BYTE_BITS : dat_nbits;
                        state_next = chd_pkg::DS_BIT;
                    end
                end
            end
            chd_pkg::DS_BIT: begin
                byte_next  = {byte_reg[chd_pkg::BYTE_W-2:0], 1'b0};
                nbits_next = nbits_reg - chd_pkg::NBITS_W'(1);
                if (hit || at_end) begin
                    sym_rd_en     = hit;
                    pend_bad_next = hit ? (off >= OFF_W'(SYMBOL_COUNT)) : 1'b1;
                    partial_next  = '0;
                    first_next    = '0;
                    base_next     = '0;
                    len_next      = '0;
                    state_next    = chd_pkg::DS_SYM;
                end else begin
                    partial_next = code_shift;
                    first_next   = CODE_W'({first_sum, 1'b0});
                    base_next    = CNT_W'(base_sum);
                    len_next     = len_reg + LEN_W'(1);
                    state_next   = (nbits_reg == chd_pkg::NBITS_W'(1)) ?
                                   chd_pkg::DS_FLUSH : chd_pkg::DS_BIT;
                end
            end
            chd_pkg::DS_SYM: begin
                // older held result goes out first, not the last of this word
                if (!held_valid_reg || out_free) begin
                    if (held_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_sym_next   = held_sym_reg;
                        out_bad_next   = held_bad_reg;
                        out_last_next  = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_sym_next   = new_sym;
                    held_bad_next   = pend_bad_reg;
                    state_next      = (nbits_reg == '0) ? chd_pkg::DS_FLUSH
                                                        : chd_pkg::DS_BIT;
                end
            end
            chd_pkg::DS_FLUSH: begin
                if (!held_valid_reg) begin
                    state_next = chd_pkg::DS_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_sym_next    = held_sym_reg;
                    out_bad_next    = held_bad_reg;
                    out_last_next   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = chd_pkg::DS_IDLE;
                end
            end
            default: begin
                state_next = chd_pkg::DS_IDLE;
            end
        endcase
    end

    assign idle       = (state_reg == chd_pkg::DS_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_symbol = out_sym_reg;
    assign out_bad    = out_bad_reg;
    assign out_last   = out_last_reg;

endmodule

/* hdl/canonical_huffman_decoder_top.sv */
// Top level of the canonical Huffman decoder: stream ports and field packing.
//
// Takes a canonical Huffman table as bytes (longest length, one count per length,
// the symbols) and then compressed bytes, decoding their bits MSB first. A table
// word is taken whenever the bit engine is idle. A data word is accepted, then its
// valid bits are stepped one at a time, with a symbol memory read for each completed
// code, and its final result is moved to the output register before the next word
// is taken; the bit loop runs one length-count memory read per bit. The last result
// of a word is held back until the word's bits are used up so that it can carry
// tlast. A data word seen with no sound table loaded gives one result with the bad
// flag set.
module canonical_huffman_decoder_top #(
    parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = chd_pkg::SYMBOL_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] byte_value, [11:8] bits_valid, [15:12] zero
    input  logic [1:0]  s_tuser,   // [0] req_type, [1] start_flag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] symbol
    output logic        m_tuser,   // [0] bad_code
    output logic        m_tlast
);

    localparam int LL_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int POS_W = $clog2(((SYMBOL_COUNT > MAX_CODE_LEN) ? SYMBOL_COUNT
                                                                 : MAX_CODE_LEN) + 1);

    chd_pkg::tbl_ctl_t             ctl;
    logic [LL_W-1:0]               longest;
    logic [POS_W-1:0]              wr_addr;
    logic [chd_pkg::BYTE_W-1:0]    wr_data;
    logic                          accept;
    logic                          idle;

    // Input word accept and routing
    assign accept   = s_tvalid && s_tready;
    assign s_tready = idle;

    chd_loader #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_loader (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tbl_valid (accept && !s_tuser[0]),
        .tbl_start (s_tuser[1]),
        .tbl_byte  (s_tdata[7:0]),
        .ctl       (ctl),
        .longest   (longest),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    chd_bit_engine #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .longest    (longest),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .dat_valid  (accept && s_tuser[0]),
        .dat_start  (s_tuser[1]),
        .dat_byte   (s_tdata[7:0]),
        .dat_nbits  (s_tdata[11:8]),
        .idle       (idle),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_symbol (m_tdata),
        .out_bad    (m_tuser),
        .out_last   (m_tlast)
    );

endmodule

/* test/tb_canonical_huffman_decoder_top.sv */
// Testbench for the canonical Huffman decoder: table and data words against a bit-level predictor.

// Predicts decoded symbols word by word and checks the result stream in order.
class huffman_scoreboard;
    typedef struct {
        logic [7:0] symbol;
        logic       bad;
        logic       last;
    } decoded_t;

    decoded_t        pending_symbols[$];
    int              errors;

    // Predictor copy of the decoder state
    logic [7:0]      len_count[chd_pkg::MAX_CODE_LEN_DEF];
    logic [7:0]      sym_store[chd_pkg::SYMBOL_COUNT_DEF];
    int              longest;
    chd_pkg::phase_t phase;
    int              load_pos;
    int              sym_total;
    logic [31:0]     code_bits;
    logic [31:0]     first_code;
    logic [8:0]      base_index;
    int              code_len;

    function new();
        errors    = 0;
        longest   = 0;
        phase     = chd_pkg::PH_NONE;
        load_pos  = 0;
        sym_total = 0;
        foreach (len_count[i]) len_count[i] = '0;
        foreach (sym_store[i]) sym_store[i] = '0;
        restart_code();
    endfunction

    function void restart_code();
        code_bits  = '0;
        first_code = '0;
        base_index = '0;
        code_len   = 0;
    endfunction

    // Kraft check over the loaded counts; an empty table is not sound either
    function bit table_sound();
        longint unsigned left;
        left = 1;
        if (sym_total == 0) return 1'b0;
        for (int l = 0; l < longest && l < chd_pkg::MAX_CODE_LEN_DEF; l++) begin
            left = left << 1;
            if (longint'(len_count[l]) > left) return 1'b0;
            left = left - len_count[l];
        end
        return 1'b1;
    endfunction

    function void load_table_byte(bit start, logic [7:0] value);
        if (start) begin
            restart_code();
            load_pos  = 0;
            sym_total = 0;
            if (value == 0 || value > chd_pkg::MAX_CODE_LEN_DEF) begin
                longest = 0;
                phase   = chd_pkg::PH_NONE;
            end else begin
                longest = value;
                phase   = chd_pkg::PH_COUNTS;
            end
            return;
        end
        if (phase == chd_pkg::PH_COUNTS) begin
            if (load_pos < chd_pkg::MAX_CODE_LEN_DEF) len_count[load_pos] = value;
            sym_total += value;
            load_pos++;
            if (sym_total > chd_pkg::SYMBOL_COUNT_DEF) begin
                sym_total = 0;
                phase     = chd_pkg::PH_NONE;
            end else if (load_pos >= longest) begin
                load_pos = 0;
                phase    = table_sound() ? chd_pkg::PH_SYMBOLS : chd_pkg::PH_NONE;
            end
        end else if (phase == chd_pkg::PH_SYMBOLS) begin
            if (load_pos < chd_pkg::SYMBOL_COUNT_DEF) sym_store[load_pos] = value;
            load_pos++;
            if (load_pos >= sym_total) begin
                load_pos = 0;
                phase    = chd_pkg::PH_READY;
            end
        end
    endfunction

    // One bit of the first-code / index walk; returns 1 when a code completes
    function bit shift_in(bit b, output logic [7:0] sym, output logic bad);
        longint unsigned cnt, code, fst, off;
        code_bits = {code_bits[30:0], b};
        code_len++;
        cnt  = (code_len >= 1 && code_len <= chd_pkg::MAX_CODE_LEN_DEF) ?
               longint'(len_count[code_len-1]) : 0;
        code = code_bits;
        fst  = first_code;
        if (code >= fst && code - fst < cnt) begin
            off = longint'(base_index) + (code - fst);
            bad = (off < chd_pkg::SYMBOL_COUNT_DEF) ? 1'b0 : 1'b1;
            sym = bad ? 8'h00 : sym_store[int'(off)];
            restart_code();
            return 1'b1;
        end
        if (code_len >= longest || code_len >= chd_pkg::MAX_CODE_LEN_DEF) begin
            sym = 8'h00;
            bad = 1'b1;
            restart_code();
            return 1'b1;
        end
        base_index = 9'((longint'(base_index) + cnt) & 64'h1FF);
        first_code = 32'((fst + cnt) << 1);
        return 1'b0;
    endfunction

    // Accepted input word: update state and queue the symbols it yields
    function void note_word(bit is_data, bit start, logic [7:0] value, logic [3:0] nbits);
        decoded_t   held;
        bit         have_held;
        int         n;
        logic [7:0] sym;
        logic       bad;
        if (!is_data) begin
            load_table_byte(start, value);
            return;
        end
        if (start) restart_code();
        if (phase != chd_pkg::PH_READY) begin
            held.symbol = 8'h00;
            held.bad    = 1'b1;
            held.last   = 1'b1;
            pending_symbols.push_back(held);
            return;
        end
        n = (nbits > 8) ? 8 : int'(nbits);
        have_held = 1'b0;
        // hold one back so the final one of the word can be marked last
        for (int i = 0; i < n; i++) begin
            if (shift_in(value[7-i], sym, bad)) begin
                if (have_held) pending_symbols.push_back(held);
                held.symbol = sym;
                held.bad    = bad;
                held.last   = 1'b0;
                have_held   = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            pending_symbols.push_back(held);
        end
    endfunction

    // Accepted output word: compare with the oldest expectation
    function void check_symbol(logic [7:0] sym, logic bad, logic last);
        decoded_t want;
        if (pending_symbols.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected: symbol %02h bad %0b last %0b",
                     $time, sym, bad, last);
            return;
        end
        want = pending_symbols.pop_front();
        if (sym !== want.symbol) begin
            errors++;
            $display("%0t: symbol mismatch: expected %02h, got %02h", $time, want.symbol, sym);
        end
        if (bad !== want.bad) begin
            errors++;
            $display("%0t: bad_code mismatch: expected %0b, got %0b", $time, want.bad, bad);
        end
        if (last !== want.last) begin
            errors++;
            $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, last);
        end
    endfunction
endclass

module tb_canonical_huffman_decoder_top;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_WORDS  = 350;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam bit REQ_TABLE     = 1'b0;
    localparam bit REQ_DATA      = 1'b1;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;
    typedef enum int {TREE_FULL, TREE_GAPPY, TREE_OVERFULL} tree_shape_t;
    typedef enum int {BAD_LENGTH, BAD_EMPTY, BAD_OVERFULL, BAD_OVERSUM, BAD_CUT} broken_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] byte_value, [11:8] bits_valid, [15:12] zero
    logic [1:0]  s_tuser;   // [0] req_type, [1] start_flag
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] symbol
    logic        m_tuser;   // [0] bad_code
    logic        m_tlast;

    huffman_scoreboard sb;
    bit [7:0]          table_bytes[$];
    int                words_sent  = 0;
    int                burst_left  = 0;
    int                cycle_count = 0;
    bit                hold_req    = 1'b0;

    canonical_huffman_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run-time guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_symbol(m_tdata, m_tuser, m_tlast);
    end

    // Receiver: stall pattern changes every so often; long hold on request
    initial begin
        rx_mode_t mode;
        int       span;
        int       period;
        int       tick;
        m_tready <= 1'b0;
        mode   = RX_OPEN;
        span   = 0;
        period = 2;
        tick   = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            if (span == 0) begin
                mode   = rx_mode_t'($urandom_range(0, 3));
                span   = $urandom_range(20, 120);
                period = $urandom_range(2, 5);
            end
            span--;
            tick++;
            case (mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= ($urandom_range(0, 1) == 0);
                RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                default:   m_tready <= (tick % period == 0);
            endcase
        end
    end

    // Sender pacing: bursts of random length, separated by gaps with s_tvalid low
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 24);
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_word(input bit is_data, input bit start, input logic [7:0] value,
                             input logic [3:0] nbits);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, nbits, value};
        s_tuser  <= {start, is_data};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(is_data, start, value, nbits);
        words_sent++;
        pace();
    endtask

    task automatic send_data(input bit start, input logic [7:0] value, input logic [3:0] nbits);
        send_word(REQ_DATA, start, value, nbits);
    endtask

    task automatic send_table();
        foreach (table_bytes[i])
            send_word(REQ_TABLE, i == 0, table_bytes[i], 4'($urandom_range(0, 15)));
    endtask

    // Sender pauses until every expected word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_symbols.size() != 0);
    endtask

    // Data word; if biased, weighted toward all-ones and all-zeros to reach long codes
    task automatic send_random_data(input bit biased);
        logic [7:0] value;
        logic [3:0] nbits;
        int         pick;
        pick  = $urandom_range(0, 19);
        value = 8'($urandom_range(0, 255));
        if (biased && pick < 3) value = 8'hFF;
        else if (biased && pick < 5) value = 8'h00;
        pick = $urandom_range(0, 19);
        if (pick < 14) nbits = 4'd8;
        else if (pick < 17) nbits = 4'($urandom_range(1, 7));
        else if (pick == 17) nbits = 4'd0;
        else nbits = 4'($urandom_range(9, 15));
        send_data($urandom_range(0, 9) == 0, value, nbits);
    endtask

    // Grow a code tree by splitting leaves, then serialize it into table_bytes
    task automatic make_table(input int len, input int leaves, input bit chain,
                              input tree_shape_t shape);
        int depth_cnt[34];
        int n, d, pick;
        foreach (depth_cnt[k]) depth_cnt[k] = 0;
        depth_cnt[1] = 2;
        n = 2;
        while (n < leaves) begin
            d = 0;
            if (chain) begin
                for (int k = len - 1; k >= 1; k--)
                    if (d == 0 && depth_cnt[k] > 0) d = k;
            end else if (len > 1) begin
                for (int t = 0; t < 8 && d == 0; t++) begin
                    pick = $urandom_range(1, len - 1);
                    if (depth_cnt[pick] > 0) d = pick;
                end
                for (int k = 1; k < len && d == 0; k++)
                    if (depth_cnt[k] > 0) d = k;
            end
            if (d == 0) break;
            depth_cnt[d]--;
            depth_cnt[d+1] += 2;
            n++;
        end
        // drop one leaf for a gappy code, add one for an over-subscribed one
        if (shape == TREE_GAPPY && n > 1) begin
            d = 0;
            for (int k = len; k >= 1; k--)
                if (d == 0 && depth_cnt[k] > 0) d = k;
            depth_cnt[d]--;
            n--;
        end
        if (shape == TREE_OVERFULL) begin
            d = $urandom_range(1, len);
            depth_cnt[d]++;
            n++;
        end
        table_bytes.delete();
        table_bytes.push_back(8'(len));
        for (int k = 1; k <= len; k++) table_bytes.push_back(8'(depth_cnt[k]));
        repeat (n) table_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic make_sound_table();
        int len, leaves, pick;
        bit chain;
        pick = $urandom_range(0, 19);
        if (pick < 15) len = $urandom_range(1, 8);
        else if (pick < 19) len = $urandom_range(9, 16);
        else len = $urandom_range(17, 32);
        pick = $urandom_range(0, 19);
        if (pick < 16) leaves = $urandom_range(2, 12);
        else if (pick < 19) leaves = $urandom_range(13, 64);
        else leaves = $urandom_range(65, 255);
        chain = ($urandom_range(0, 3) == 0);
        if (len > 16 && $urandom_range(0, 1) == 1) begin
            chain  = 1'b1;
            leaves = len + 1;
        end
        make_table(len, leaves, chain, ($urandom_range(0, 3) == 0) ? TREE_GAPPY : TREE_FULL);
    endtask

    // Stimulus
    initial begin
        int      base_words;
        int      pick;
        int      len;
        int      first_cnt;
        broken_t flaw;
        sb = new();
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        aresetn  <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // data before any table, stray table word, bad longest lengths
        send_data(1'b0, 8'h5A, 4'd8);
        send_word(REQ_TABLE, 1'b0, 8'h03, 4'd8);
        table_bytes = '{8'd0};
        send_table();
        send_data(1'b1, 8'hFF, 4'd8);
        table_bytes = '{8'd33};
        send_table();

        // codes: 0 -> AA, 10 -> 00, 11 -> FF
        table_bytes = '{8'd2, 8'd1, 8'd2, 8'hAA, 8'h00, 8'hFF};
        send_table();
        send_data(1'b0, 8'h00, 4'd8);
        send_data(1'b0, 8'hFF, 4'd8);
        send_data(1'b0, 8'hB4, 4'd7);
        send_data(1'b0, 8'h80, 4'd1);
        send_data(1'b1, 8'h00, 4'd12);      // start drops the pending bit; count above 8
        send_data(1'b0, 8'h80, 4'd1);
        send_data(1'b0, 8'h7F, 4'd0);       // no bits used
        send_data(1'b0, 8'h40, 4'd2);       // code spans words
        send_word(REQ_TABLE, 1'b0, 8'hFF, 4'd15);   // ignored once loaded
        send_data(1'b0, 8'h80, 4'd1);

        // gappy code gives invalid codes
        table_bytes = '{8'd3, 8'd1, 8'd0, 8'd1, 8'h05, 8'h06};
        send_table();
        send_data(1'b0, 8'hFF, 4'd8);

        // over-subscribed code
        table_bytes = '{8'd2, 8'd2, 8'd1};
        send_table();
        send_data(1'b0, 8'h00, 4'd8);
        drain();

        base_words = words_sent;
        for (int scene = 0; words_sent < base_words + RANDOM_WORDS; scene++) begin
            pick = $urandom_range(0, 19);
            if (scene == 0 || pick < 13) begin
                // sound table followed by data; first one is the longest chain
                if (scene == 0) make_table(chd_pkg::MAX_CODE_LEN_DEF,
                                           chd_pkg::MAX_CODE_LEN_DEF + 1, 1'b1,
                                           TREE_FULL);
                else make_sound_table();
                send_table();
                if (scene == 0) hold_req = 1'b1;
                repeat ((scene == 0) ? 30 : $urandom_range(4, 24)) begin
                    if ($urandom_range(0, 14) == 0)
                        send_word(REQ_TABLE, 1'b0, 8'($urandom_range(0, 255)),
                                  4'($urandom_range(0, 15)));
                    else
                        send_random_data(1'b1);
                end
                if (scene == 0 || $urandom_range(0, 4) == 0) drain();
            end else if (pick < 17) begin
                // broken or cut-short table
                flaw = broken_t'($urandom_range(0, 4));
                case (flaw)
                    BAD_LENGTH: begin
                        table_bytes.delete();
                        table_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'd0 :
                                              8'($urandom_range(33, 255)));
                    end
                    BAD_EMPTY: begin
                        len = $urandom_range(1, 6);
                        table_bytes.delete();
                        table_bytes.push_back(8'(len));
                        repeat (len) table_bytes.push_back(8'd0);
                    end
                    BAD_OVERFULL: make_table($urandom_range(1, 6), $urandom_range(2, 8), 1'b0,
                                             TREE_OVERFULL);
                    BAD_OVERSUM: begin
                        len = $urandom_range(2, 5);
                        first_cnt = $urandom_range(2, 255);
                        table_bytes.delete();
                        table_bytes.push_back(8'(len));
                        table_bytes.push_back(8'(first_cnt));
                        table_bytes.push_back(8'($urandom_range(257 - first_cnt, 255)));
                        repeat (len - 2) table_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        make_sound_table();
                        repeat ($urandom_range(1, 3))
                            if (table_bytes.size() > 1) void'(table_bytes.pop_back());
                    end
                endcase
                send_table();
                repeat ($urandom_range(0, 2))
                    send_word(REQ_TABLE, 1'b0, 8'($urandom_range(0, 255)),
                              4'($urandom_range(0, 15)));
                repeat ($urandom_range(1, 3)) send_random_data(1'b0);
            end else begin
                // noise on whatever table is loaded
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 2) == 0)
                        send_word(REQ_TABLE, 1'b0, 8'($urandom_range(0, 255)),
                                  4'($urandom_range(0, 15)));
                    else
                        send_random_data(1'b0);
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_symbols.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
